FILE: sv/isbe_pkg.sv
// Package for the I2C slave byte engine: bus event codes and default sizes.
// No dependencies; used by the channel interfaces and the top level.

package isbe_pkg;

  // Bus event codes carried on the event channel.
  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_STOP  = 2'd1,
    EV_RISE  = 2'd2,
    EV_FALL  = 2'd3
  } bus_event_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_OWN_ADDRESS   = 1'b0,
    REG_BUFFER_LENGTH = 1'b1
  } cfg_reg_t;

  localparam int BUF_DEPTH_DEF = 16;
  localparam int BITS_PER_BYTE = 8;
  localparam logic [6:0] OWN_ADDRESS_RST = 7'd0;
  localparam logic [4:0] BUFFER_LENGTH_RST = 5'd16;

endpackage

FILE: sv/isbe_evt_if.sv
// Event channel interface: one bus event word (event code and sampled SDA).
// Depends on isbe_pkg for the event code type.

interface isbe_evt_if
  import isbe_pkg::*;
();
  logic       valid;
  logic       ready;
  bus_event_t func;
  logic       sda_level;

  modport source (output valid, output func, output sda_level, input ready);
  modport sink   (input valid, input func, input sda_level, output ready);
endinterface

FILE: sv/isbe_res_if.sv
// Result channel interface: one result word per bus event.
// Imports isbe_pkg, though it uses none of its types.

interface isbe_res_if
  import isbe_pkg::*;
();
  logic valid;
  logic ready;
  logic sda_pull_low;
  logic transfer_done;
  logic addressed;
  logic master_reads;

  modport source (output valid, output sda_pull_low, output transfer_done,
                  output addressed, output master_reads, input ready);
  modport sink   (input valid, input sda_pull_low, input transfer_done,
                  input addressed, input master_reads, output ready);
endinterface

FILE: sv/i2c_slave_byte_engine.sv
// I2C slave byte engine: the event-driven slave with its byte buffer and APB registers.
// Depends on isbe_pkg, isbe_evt_if and isbe_res_if.
//
// Usage: each word on in_if is one bus event (start, stop, SCL rising or
// SCL falling) with the SDA level sampled at that event. For every event
// word exactly one result word leaves on out_if: the SDA pull-low drive,
// a transfer-done pulse, and the addressed and master-reads flags.
// The slave matches the address byte against own_address and then stores
// written bytes into, or sends read bytes from, a circular buffer whose
// used length is buffer_length (0 acts as 1, values above the depth act as
// the depth). The user must write the registers over the APB port only while
// the block is idle; the block itself does not enforce this. An input register
// takes the event, and one pass of logic from it updates the slave state and
// the result register. Throughput is one event per cycle while out_if does not
// stall; the state update is a single step, and the buffer read and write fit
// within that step. When out_if stalls, an empty input register still takes
// one more event, and then in_if.ready drops until the result word is taken.
// Reset (rst_n low, synchronous) empties both stages, returns the slave to
// idle, restores the register defaults and marks every buffer entry as zero.

module i2c_slave_byte_engine
  import isbe_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  isbe_evt_if.sink          in_if,
  isbe_res_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = (LW > 5) ? LW : 5;
  localparam logic [3:0] BITS_FULL = 4'(BITS_PER_BYTE);

  // Configuration registers.
  logic [6:0] own_address_r;
  logic [4:0] buffer_length_r;

  // Input stage.
  logic       in_valid_r;
  bus_event_t func_r;
  logic       sda_r;

  // Output stage.
  logic out_valid_r;
  logic sda_pull_low_r, transfer_done_r, addressed_r, master_reads_r;

  // Slave state.
  logic          bus_active_r, bus_active_nxt;
  logic          sending_r, sending_nxt;
  logic          matched_r, matched_nxt;
  logic          ignoring_r, ignoring_nxt;
  logic          wdir_r, wdir_nxt;
  logic [3:0]    bits_left_r, bits_left_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          past_addr_r, past_addr_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          drive_r, drive_nxt;

  // Byte buffer; an entry not yet written reads as zero.
  logic [7:0]              buf_mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] buf_vld_r;

  logic          adv, step;
  logic          done;
  logic          wr_en;
  logic [CW-1:0] len_ext, eff_c;
  logic [LW-1:0] eff_len, slot;
  logic [AW-1:0] slot_a;
  logic [7:0]    rd_slot, rd_zero;
  logic [3:0]    bits_dec;
  logic [7:0]    shift_in;
  logic          master_acked;

  assign adv  = !out_valid_r || out_if.ready;
  assign step = adv && in_valid_r;
  assign in_if.ready = !in_valid_r || adv;

  // Effective length and the slot the next buffer access uses.
  always_comb begin
    len_ext = CW'(buffer_length_r);
    if (len_ext == '0) begin
      eff_c = CW'(1);
    end else if (len_ext > CW'(BUFFER_DEPTH)) begin
      eff_c = CW'(BUFFER_DEPTH);
    end else begin
      eff_c = len_ext;
    end
    eff_len = LW'(eff_c);
    slot    = (idx_r >= eff_len) ? '0 : idx_r;
    slot_a  = slot[AW-1:0];
    rd_slot = buf_vld_r[slot_a] ? buf_mem[slot_a] : 8'd0;
    rd_zero = buf_vld_r[0] ? buf_mem[0] : 8'd0;
  end

  always_comb begin
    bus_active_nxt = bus_active_r;
    sending_nxt    = sending_r;
    matched_nxt    = matched_r;
    ignoring_nxt   = ignoring_r;
    wdir_nxt       = wdir_r;
    bits_left_nxt  = bits_left_r;
    shift_nxt      = shift_r;
    past_addr_nxt  = past_addr_r;
    idx_nxt        = idx_r;
    drive_nxt      = drive_r;
    done           = 1'b0;
    wr_en          = 1'b0;
    bits_dec       = bits_left_r - 4'd1;
    shift_in       = shift_r | (8'(sda_r) << bits_dec[2:0]);
    master_acked   = !sda_r;

    case (func_r)
      EV_START: begin
        matched_nxt    = 1'b0;
        bits_left_nxt  = BITS_FULL;
        shift_nxt      = 8'd0;
        wdir_nxt       = 1'b0;
        past_addr_nxt  = 1'b0;
        sending_nxt    = 1'b0;
        ignoring_nxt   = 1'b0;
        drive_nxt      = 1'b0;
        bus_active_nxt = 1'b1;
      end
      EV_STOP: begin
        done           = bus_active_r;
        bus_active_nxt = 1'b0;
        matched_nxt    = 1'b0;
        sending_nxt    = 1'b0;
        ignoring_nxt   = 1'b0;
        drive_nxt      = 1'b0;
      end
      EV_RISE, EV_FALL: begin
        if (bus_active_r && !ignoring_r) begin
          if (sending_r) begin
            if (func_r == EV_FALL) begin
              if (bits_left_r != 4'd0 && bits_left_r <= BITS_FULL) begin
                drive_nxt = !shift_r[bits_dec[2:0]];
              end else begin
                drive_nxt = 1'b0;
              end
            end else if (bits_left_r != 4'd0) begin
              bits_left_nxt = bits_dec;
            end else if (master_acked) begin
              shift_nxt     = rd_slot;
              idx_nxt       = slot + LW'(1);
              bits_left_nxt = BITS_FULL;
            end else begin
              // Master NACK ends the read.
              drive_nxt      = 1'b0;
              bus_active_nxt = 1'b0;
              done           = 1'b1;
            end
          end else begin
            if (func_r == EV_FALL) begin
              if (matched_r) begin
                if (bits_left_r == BITS_FULL) begin
                  drive_nxt = 1'b0;
                end else if (bits_left_r == 4'd0) begin
                  drive_nxt = 1'b1;
                end
              end
            end else if (bits_left_r != 4'd0) begin
              bits_left_nxt = bits_dec;
              shift_nxt     = shift_in;
              if (!past_addr_r && bits_dec == 4'd0) begin
                wdir_nxt    = !shift_in[0];
                matched_nxt = (shift_in[7:1] == own_address_r);
                idx_nxt     = '0;
              end
            end else begin
              // Ninth rising edge: the byte is complete.
              bits_left_nxt = BITS_FULL;
              shift_nxt     = 8'd0;
              if (matched_r) begin
                past_addr_nxt = 1'b1;
                if (!past_addr_r) begin
                  if (!wdir_r) begin
                    shift_nxt   = rd_zero;
                    idx_nxt     = LW'(1);
                    sending_nxt = 1'b1;
                  end
                end else begin
                  wr_en   = 1'b1;
                  idx_nxt = slot + LW'(1);
                end
              end else begin
                ignoring_nxt = 1'b1;
                drive_nxt    = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      own_address_r   <= OWN_ADDRESS_RST;
      buffer_length_r <= BUFFER_LENGTH_RST;
      bus_active_r    <= 1'b0;
      sending_r       <= 1'b0;
      matched_r       <= 1'b0;
      ignoring_r      <= 1'b0;
      wdir_r          <= 1'b0;
      bits_left_r     <= BITS_FULL;
      shift_r         <= 8'd0;
      past_addr_r     <= 1'b0;
      idx_r           <= '0;
      drive_r         <= 1'b0;
      buf_vld_r       <= '0;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[2]))
          REG_OWN_ADDRESS:   own_address_r   <= pwdata[6:0];
          REG_BUFFER_LENGTH: buffer_length_r <= pwdata[4:0];
          default: begin
          end
        endcase
      end
      if (step) begin
        bus_active_r <= bus_active_nxt;
        sending_r    <= sending_nxt;
        matched_r    <= matched_nxt;
        ignoring_r   <= ignoring_nxt;
        wdir_r       <= wdir_nxt;
        bits_left_r  <= bits_left_nxt;
        shift_r      <= shift_nxt;
        past_addr_r  <= past_addr_nxt;
        idx_r        <= idx_nxt;
        drive_r      <= drive_nxt;
        if (wr_en) begin
          buf_vld_r[slot_a] <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      func_r <= in_if.func;
      sda_r  <= in_if.sda_level;
    end
    if (step) begin
      sda_pull_low_r  <= drive_nxt;
      transfer_done_r <= done;
      addressed_r     <= matched_nxt;
      master_reads_r  <= matched_nxt && !wdir_nxt;
      if (wr_en) begin
        buf_mem[slot_a] <= shift_r;
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.sda_pull_low  = sda_pull_low_r;
  assign out_if.transfer_done = transfer_done_r;
  assign out_if.addressed     = addressed_r;
  assign out_if.master_reads  = master_reads_r;

  assign pready = 1'b1;
  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_OWN_ADDRESS:   prdata = 32'(own_address_r);
      REG_BUFFER_LENGTH: prdata = 32'(buffer_length_r);
      default:           prdata = 32'd0;
    endcase
  end

`ifndef ASSERT_OFF
  // A finished transfer never leaves SDA pulled low.
  a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && transfer_done_r) |-> !sda_pull_low_r)
    else $error("transfer done while SDA is still driven low");

  // A stalled result word freezes the slave state.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> ($stable(bits_left_r) && $stable(idx_r)
                                        && $stable(bus_active_r)))
    else $error("slave state moved while the result word was stalled");

  // The buffer index and bit counter stay within their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r <= LW'(BUFFER_DEPTH)) && (bits_left_r <= BITS_FULL))
    else $error("buffer index or bit counter out of range");

  // A read direction is only reported for an addressed transfer.
  a_reads_addressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && master_reads_r) |-> addressed_r)
    else $error("master reads reported without a matching address");
`endif

endmodule
